### rtl/cls_pkg.sv
`default_nettype none

package cls_pkg;

    localparam int DEFAULT_ROWS = 24;
    localparam int DEFAULT_COLS = 32;

    localparam int PIX_W   = 8;
    localparam int GUARD_W = 9;
    localparam int GAIN_W  = 3;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 3;

    localparam logic               RST_SHARPEN_ENABLE  = 1'b1;
    localparam logic [PIX_W-1:0]   RST_MIN_DIFFERENCE  = 8'd2;
    localparam logic [PIX_W-1:0]   RST_MAX_DIFFERENCE  = 8'd24;
    localparam logic [GUARD_W-1:0] RST_HIGHLIGHT_GUARD = 9'd220;
    localparam logic [GAIN_W-1:0]  RST_GAIN_NUMERATOR  = 3'd2;

    // Division by five as a multiply by ceil(2^16 / 5) and a 16-bit shift; exact
    // for dividends below 2^14.
    localparam int            DIV5_SHIFT = 16;
    localparam logic [13:0]   DIV5_RECIP = 14'd13108;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHARPEN_ENABLE  = 3'd0,
        REG_MIN_DIFFERENCE  = 3'd1,
        REG_MAX_DIFFERENCE  = 3'd2,
        REG_HIGHLIGHT_GUARD = 3'd3,
        REG_GAIN_NUMERATOR  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] gray_in;
        logic             frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] gray_out;
        logic             frame_last;
    } pix_out_t;

endpackage

`default_nettype wire

### rtl/cross_laplacian_sharpen.sv
// Each result passes through the stage 1, 2 and 3 registers and then the output register.
// Throughput: one pixel per cycle unless m_ready stalls the output; the last pixel of a frame
// adds ROWS flush beats, during which s_ready is low.
// Reset: synchronous, active low; clears the position count, the pipeline valids and
// the configuration registers to their defaults; the pixel line itself is not cleared.
`default_nettype none

module cross_laplacian_sharpen
    import cls_pkg::*;
#(
    parameter int ROWS = DEFAULT_ROWS,
    parameter int COLS = DEFAULT_COLS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pix_in_t              s_data,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pix_out_t                  m_data
);

    localparam int LINE_DEPTH = 2 * ROWS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLS);
    localparam int FLUSH_W    = $clog2(ROWS + 1);

    // Configuration registers.
    logic               enable_reg;
    logic [PIX_W-1:0]   min_diff_reg;
    logic [PIX_W-1:0]   max_diff_reg;
    logic [GUARD_W-1:0] guard_reg;
    logic [GAIN_W-1:0]  gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= RST_SHARPEN_ENABLE;
            min_diff_reg <= RST_MIN_DIFFERENCE;
            max_diff_reg <= RST_MAX_DIFFERENCE;
            guard_reg    <= RST_HIGHLIGHT_GUARD;
            gain_reg     <= RST_GAIN_NUMERATOR;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SHARPEN_ENABLE:  enable_reg   <= cfg_data[0];
                REG_MIN_DIFFERENCE:  min_diff_reg <= cfg_data[PIX_W-1:0];
                REG_MAX_DIFFERENCE:  max_diff_reg <= cfg_data[PIX_W-1:0];
                REG_HIGHLIGHT_GUARD: guard_reg    <= cfg_data;
                REG_GAIN_NUMERATOR:  gain_reg     <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: every stage moves when the output register is free.
    logic advance;
    logic s_accept;
    logic flush_go;
    logic out_valid_reg;

    logic [FLUSH_W-1:0] flush_cnt_reg, flush_cnt_next;
    logic [ROW_W-1:0]   row_reg, row_next, row_cur;
    logic [COL_W-1:0]   col_reg, col_next, col_cur;
    logic               at_last;

    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = advance && (flush_cnt_reg == '0);
    assign s_accept = s_valid && s_ready;
    assign flush_go = advance && (flush_cnt_reg != '0);

    assign row_cur = s_data.frame_start ? '0 : row_reg;
    assign col_cur = s_data.frame_start ? '0 : col_reg;
    assign at_last = (row_cur == ROW_W'(ROWS - 1)) && (col_cur == COL_W'(COLS - 1));

    always_comb begin
        row_next       = row_reg;
        col_next       = col_reg;
        flush_cnt_next = flush_cnt_reg;
        if (s_accept) begin
            if (at_last) begin
                row_next       = '0;
                col_next       = '0;
                flush_cnt_next = FLUSH_W'(ROWS);
            end else if (row_cur == ROW_W'(ROWS - 1)) begin
                row_next = '0;
                col_next = col_cur + 1'b1;
            end else begin
                row_next = row_cur + 1'b1;
                col_next = col_cur;
            end
        end else if (flush_go) begin
            flush_cnt_next = flush_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            flush_cnt_reg <= '0;
        end else begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            flush_cnt_reg <= flush_cnt_next;
        end
    end

    // Pixel line: the newest pixel enters at index 0. Flush beats keep shifting so that
    // the pixel due next always sits at the centre tap.
    logic [PIX_W-1:0] line_reg [LINE_DEPTH];

    always_ff @(posedge aclk) begin
        if (s_accept || flush_go) begin
            line_reg[0] <= s_data.gray_in;
            for (int k = 1; k < LINE_DEPTH; k++) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    // Stage 1: neighbourhood taps.
    logic             s1_valid_reg;
    logic             s1_interior_reg;
    logic             s1_last_reg;
    logic [PIX_W-1:0] s1_c_reg, s1_up_reg, s1_dn_reg, s1_lf_reg, s1_rt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= flush_go || (s_accept && (col_cur != '0));
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_c_reg        <= line_reg[ROWS-1];
            s1_up_reg       <= line_reg[ROWS];
            s1_dn_reg       <= line_reg[ROWS-2];
            s1_lf_reg       <= line_reg[LINE_DEPTH-1];
            s1_rt_reg       <= s_data.gray_in;
            s1_interior_reg <= !flush_go && (row_cur != '0) && (row_cur != ROW_W'(ROWS - 1))
                               && (col_cur >= COL_W'(2));
            s1_last_reg     <= flush_go && (flush_cnt_reg == FLUSH_W'(1));
        end
    end

    // Stage 2: difference against the neighbour average, bypass decision and clamp.
    logic [PIX_W+1:0]        sum4;
    logic [PIX_W-1:0]        avg;
    logic signed [PIX_W:0]   diff, lim, diff_clamp;
    logic [PIX_W:0]          mag;
    logic                    bypass;

    always_comb begin
        sum4 = {2'b00, s1_up_reg} + {2'b00, s1_dn_reg} + {2'b00, s1_lf_reg}
             + {2'b00, s1_rt_reg};
        avg  = sum4[PIX_W+1:2];
        diff = $signed({1'b0, s1_c_reg}) - $signed({1'b0, avg});
        mag  = diff[PIX_W] ? unsigned'(-diff) : unsigned'(diff);
        lim  = $signed({1'b0, max_diff_reg});
        bypass = !s1_interior_reg || !enable_reg || (mag < {1'b0, min_diff_reg})
               || (({1'b0, s1_c_reg} >= guard_reg) && !diff[PIX_W] && (diff != '0));
        if (diff > lim) begin
            diff_clamp = lim;
        end else if (diff < -lim) begin
            diff_clamp = -lim;
        end else begin
            diff_clamp = diff;
        end
    end

    logic                  s2_valid_reg;
    logic                  s2_last_reg;
    logic                  s2_bypass_reg;
    logic [PIX_W-1:0]      s2_c_reg;
    logic signed [PIX_W:0] s2_diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_last_reg   <= s1_last_reg;
            s2_bypass_reg <= bypass;
            s2_c_reg      <= s1_c_reg;
            s2_diff_reg   <= diff_clamp;
        end
    end

    // Stage 3: magnitude times gain numerator.
    logic [PIX_W-1:0] s2_abs;

    assign s2_abs = s2_diff_reg[PIX_W] ? PIX_W'(unsigned'(-s2_diff_reg))
                                       : PIX_W'(unsigned'(s2_diff_reg));

    logic                      s3_valid_reg;
    logic                      s3_last_reg;
    logic                      s3_bypass_reg;
    logic                      s3_neg_reg;
    logic [PIX_W-1:0]          s3_c_reg;
    logic [PIX_W+GAIN_W-1:0]   s3_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_last_reg   <= s2_last_reg;
            s3_bypass_reg <= s2_bypass_reg;
            s3_neg_reg    <= s2_diff_reg[PIX_W];
            s3_c_reg      <= s2_c_reg;
            s3_prod_reg   <= {{GAIN_W{1'b0}}, s2_abs} * {{PIX_W{1'b0}}, gain_reg};
        end
    end

    // Stage 4: divide by five toward zero, add to the pixel and saturate.
    logic [PIX_W+GAIN_W+13:0] quot_full;
    logic [PIX_W:0]           quot;
    logic signed [PIX_W+2:0]  sum_v;
    logic [PIX_W-1:0]         sharp;

    always_comb begin
        quot_full = {14'd0, s3_prod_reg} * {{(PIX_W+GAIN_W){1'b0}}, DIV5_RECIP};
        quot      = quot_full[DIV5_SHIFT+PIX_W:DIV5_SHIFT];
        if (s3_neg_reg) begin
            sum_v = $signed({3'b000, s3_c_reg}) - $signed({2'b00, quot});
        end else begin
            sum_v = $signed({3'b000, s3_c_reg}) + $signed({2'b00, quot});
        end
        if (sum_v < 0) begin
            sharp = '0;
        end else if (sum_v > $signed(11'd255)) begin
            sharp = '1;
        end else begin
            sharp = sum_v[PIX_W-1:0];
        end
    end

    pix_out_t out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg.gray_out   <= s3_bypass_reg ? s3_c_reg : sharp;
            out_data_reg.frame_last <= s3_last_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

### tb/cross_laplacian_sharpen_tb.sv
module cross_laplacian_sharpen_tb
    import cls_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = DEFAULT_ROWS;
    localparam int COLS = DEFAULT_COLS;
    localparam int LINE_LEN = 2 * ROWS;
    localparam int FRAME_LEN = ROWS * COLS;
    localparam int SEGMENTS = 8;
    localparam int FRAME_SEGMENT = FRAME_LEN / SEGMENTS;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT = 500;
    localparam int HOLD_CYCLES = 400;
    localparam int OPENING_LEN = 27;

    typedef struct packed {
        logic               sharpen_enable;
        logic [PIX_W-1:0]   min_difference;
        logic [PIX_W-1:0]   max_difference;
        logic [GUARD_W-1:0] highlight_guard;
        logic [GAIN_W-1:0]  gain_numerator;
    } sharpen_cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             start;
        logic             fixed;
        logic [PIX_W-1:0] want_gray;
        logic             want_last;
    } opening_row_t;

    typedef enum {SCENE_NOISE, SCENE_GRADIENT, SCENE_BINARY} scene_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    cfg_reg_t cfg_index = REG_SHARPEN_ENABLE;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    pix_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pix_out_t m_data;

    sharpen_cfg_t active_cfg = {RST_SHARPEN_ENABLE, RST_MIN_DIFFERENCE, RST_MAX_DIFFERENCE,
                                RST_HIGHLIGHT_GUARD, RST_GAIN_NUMERATOR};
    logic [PIX_W-1:0] pixel_line [LINE_LEN];
    int unsigned frame_pos = 0;
    pix_out_t expected_pixels [$];
    int mismatches = 0;

    int tx_run_left = 0;
    bit tx_run_calm = 1'b0;
    int rx_run_left = 0;
    bit rx_run_calm = 1'b0;

    // The new frame at the third beat discards the two beats before it, so the first
    // result is the border pixel that opened the new frame.
    opening_row_t opening_rows [OPENING_LEN] = '{
        '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hAA, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFE, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hEF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h33, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hCC, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFD, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h40, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h08, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hF7, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h20, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hDF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h04, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h80, 1'b0, 1'b1, 8'hFF, 1'b0}
    };

    cross_laplacian_sharpen #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #1ns aclk = ~aclk;

    initial begin
        foreach (pixel_line[k]) begin
            pixel_line[k] = '0;
        end
    end

    function automatic int draw_gap(inout int run_left, inout bit run_calm);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            run_calm = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return run_calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [PIX_W-1:0] sharpened(int c, int up, int dn, int lf, int rt);
        int diff;
        int mag;
        int lim;
        int v;
        diff = c - (up + dn + lf + rt) / 4;
        mag = (diff < 0) ? -diff : diff;
        lim = int'(active_cfg.max_difference);
        if (!active_cfg.sharpen_enable) return PIX_W'(c);
        if (mag < int'(active_cfg.min_difference)) return PIX_W'(c);
        if (c >= int'(active_cfg.highlight_guard) && diff > 0) return PIX_W'(c);
        if (diff > lim) begin
            diff = lim;
        end else if (diff < -lim) begin
            diff = -lim;
        end
        v = c + (diff * int'(active_cfg.gain_numerator)) / 5;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
    endfunction

    task automatic predict_beat(input pix_in_t beat);
        int unsigned p;
        int unsigned row;
        int unsigned col;
        pix_out_t done;
        p = beat.frame_start ? 0 : frame_pos;
        if (p >= FRAME_LEN) p = 0;
        if (p >= ROWS) begin
            row = p % ROWS;
            col = p / ROWS - 1;
            done.gray_out = pixel_line[ROWS-1];
            done.frame_last = 1'b0;
            if (row >= 1 && row + 1 < ROWS && col >= 1 && col + 1 < COLS) begin
                done.gray_out = sharpened(pixel_line[ROWS-1], pixel_line[ROWS],
                                          pixel_line[ROWS-2], pixel_line[LINE_LEN-1],
                                          beat.gray_in);
            end
            expected_pixels.push_back(done);
        end
        for (int k = LINE_LEN - 1; k > 0; k--) begin
            pixel_line[k] = pixel_line[k-1];
        end
        pixel_line[0] = beat.gray_in;
        if (p + 1 == FRAME_LEN) begin
            for (int j = 0; j < ROWS; j++) begin
                done.gray_out = pixel_line[ROWS-1-j];
                done.frame_last = (j == ROWS - 1);
                expected_pixels.push_back(done);
            end
            frame_pos = 0;
        end else begin
            frame_pos = p + 1;
        end
    endtask

    task automatic send_beat(input pix_in_t beat);
        int gap;
        gap = draw_gap(tx_run_left, tx_run_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        predict_beat(beat);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input sharpen_cfg_t next);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SHARPEN_ENABLE;
        cfg_data <= CFG_W'(next.sharpen_enable);
        @(posedge aclk);
        cfg_index <= REG_MIN_DIFFERENCE;
        cfg_data <= CFG_W'(next.min_difference);
        @(posedge aclk);
        cfg_index <= REG_MAX_DIFFERENCE;
        cfg_data <= CFG_W'(next.max_difference);
        @(posedge aclk);
        cfg_index <= REG_HIGHLIGHT_GUARD;
        cfg_data <= CFG_W'(next.highlight_guard);
        @(posedge aclk);
        cfg_index <= REG_GAIN_NUMERATOR;
        cfg_data <= CFG_W'(next.gain_numerator);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        active_cfg = next;
    endtask

    function automatic sharpen_cfg_t random_settings();
        sharpen_cfg_t s;
        s.sharpen_enable = 1'b1;
        s.min_difference = PIX_W'($urandom_range(0, 12));
        s.max_difference = PIX_W'($urandom_range(0, 255));
        s.highlight_guard = GUARD_W'($urandom_range(0, 256));
        s.gain_numerator = GAIN_W'($urandom_range(0, 7));
        return s;
    endfunction

    function automatic logic [PIX_W-1:0] scene_pixel(scene_t scene, int base, int unsigned p);
        int v;
        case (scene)
            SCENE_NOISE: begin
                return PIX_W'($urandom);
            end
            SCENE_GRADIENT: begin
                v = base + int'(p % ROWS) * 3 + int'(p / ROWS) * 2 + $urandom_range(0, 8) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return PIX_W'(v);
            end
            default: begin
                return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
        endcase
    endfunction

    // A broken run restarts the frame now and then and is always cut short.
    task automatic send_frame_run(input int unsigned length, input bit broken);
        scene_t scene;
        int base;
        int unsigned i;
        pix_in_t beat;
        scene = scene_t'($urandom_range(0, 2));
        base = $urandom_range(0, 200);
        for (i = 0; i < length; i++) begin
            beat.gray_in = scene_pixel(scene, base, i);
            if (i == 0) begin
                beat.frame_start = (frame_pos == 0) ? 1'($urandom_range(0, 1)) : 1'b1;
            end else begin
                beat.frame_start = broken && ($urandom_range(0, 39) == 0);
            end
            send_beat(beat);
        end
    endtask

    // Carries on with the frame in progress without restarting it.
    task automatic continue_frame(input int unsigned length);
        scene_t scene;
        int base;
        pix_in_t beat;
        scene = scene_t'($urandom_range(0, 2));
        base = $urandom_range(0, 200);
        for (int unsigned i = 0; i < length; i++) begin
            beat.gray_in = scene_pixel(scene, base, frame_pos);
            beat.frame_start = 1'b0;
            send_beat(beat);
        end
    endtask

    initial begin : stimulus
        pix_in_t beat;
        sharpen_cfg_t plan [$];
        plan = '{
            {1'b1, 8'd0, 8'd255, 9'd256, 3'd7},
            {1'b0, 8'd0, 8'd255, 9'd0, 3'd7},
            {1'b1, 8'd255, 8'd0, 9'd0, 3'd0},
            {1'b1, 8'd0, 8'd255, 9'd0, 3'd5},
            {1'b1, 8'd0, 8'd0, 9'd100, 3'd3}
        };
        plan.push_back(random_settings());
        plan.push_back(random_settings());
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (opening_rows[i]) begin
            beat.gray_in = opening_rows[i].gray;
            beat.frame_start = opening_rows[i].start;
            send_beat(beat);
            if (opening_rows[i].fixed) begin
                expected_pixels[expected_pixels.size()-1] =
                    {opening_rows[i].want_gray, opening_rows[i].want_last};
            end
        end
        // One whole frame, with the settings changed between its segments.
        send_frame_run(FRAME_SEGMENT, 1'b0);
        wait_drained();
        foreach (plan[i]) begin
            apply_settings(plan[i]);
            continue_frame(FRAME_SEGMENT);
            wait_drained();
        end
        send_frame_run($urandom_range(ROWS, 3 * ROWS), 1'b1);
        wait_drained();
        if (mismatches == 0) begin
            $display("cross_laplacian_sharpen test passed");
        end else begin
            $display("cross_laplacian_sharpen test failed");
        end
        $finish;
    end

    // Once, the result side holds off long enough for the block to fill and stall its input.
    initial begin : result_sink
        pix_out_t want;
        pix_out_t got;
        int gap;
        int taken;
        taken = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (taken == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_gap(rx_run_left, rx_run_calm);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            got = m_data;
            taken++;
            if (expected_pixels.size() == 0) begin
                $error("unexpected beat: gray_out %0d, frame_last %0d",
                       got.gray_out, got.frame_last);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (got.gray_out !== want.gray_out) begin
                    $error("gray_out: expected %0d, actual %0d", want.gray_out, got.gray_out);
                    mismatches++;
                end
                if (got.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, actual %0d",
                           want.frame_last, got.frame_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("cross_laplacian_sharpen test failed");
        $finish;
    end

endmodule

### cross_laplacian_sharpen.f
rtl/cls_pkg.sv
rtl/cross_laplacian_sharpen.sv
tb/cross_laplacian_sharpen_tb.sv
